### hw/rtl/rvs_pkg.sv
// Shared types and constants for the RV32I step core.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package rvs_pkg;

    localparam int MEM_BYTES = 16384;
    localparam int ROWS      = MEM_BYTES / 4;
    localparam int ROW_W     = $clog2(ROWS);

    localparam logic [31:0] MEM_TOP   = 32'(MEM_BYTES);
    localparam logic [31:0] WORD_LAST = 32'(MEM_BYTES - 4);

    localparam logic [6:0] OPC_REG    = 7'h33;
    localparam logic [6:0] OPC_IMM    = 7'h13;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_SYSTEM = 7'h73;

    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;

    localparam logic [4:0] REG_A0 = 5'd10;
    localparam logic [4:0] REG_A7 = 5'd17;

    localparam logic [31:0] CALL_PRINT = 32'd1;
    localparam logic [31:0] CALL_EXIT  = 32'd10;

    localparam logic [31:0] SP_INIT = 32'h0000_3ffc;
    localparam logic [31:0] GP_INIT = 32'h0000_1800;

    localparam logic [2:0] EV_WRITE   = 3'd0;
    localparam logic [2:0] EV_EXEC    = 3'd1;
    localparam logic [2:0] EV_PRINT   = 3'd2;
    localparam logic [2:0] EV_EXIT    = 3'd3;
    localparam logic [2:0] EV_PCFAULT = 3'd4;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FETCH,
        S_EXEC,
        S_LOAD,
        S_OUT
    } state_t;

    typedef struct packed {
        logic       op;
        logic [13:0] load_address;
        logic [7:0] load_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         event_res;
        logic signed [31:0] print_value;
        logic [31:0]        next_pc;
        logic               access_fault;
    } out_item_t;

    typedef struct packed {
        logic clear;
        logic accept;
        logic fetch;
        logic exec;
        logic load_wb;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic clear_done;
        logic need_fetch;
        logic need_load;
    } stat_t;

endpackage

`default_nettype wire

### hw/rtl/rvs_ctrl.sv
// Sequencer for the RV32I step core: memory clear, fetch, execute, load, output.
// Depends on rvs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rvs_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  wire logic          out_stall,
    input  wire rvs_pkg::stat_t stat,
    output rvs_pkg::cmd_t      cmd
);
    import rvs_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clear_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = stat.need_fetch ? S_FETCH : S_OUT;
                end
            end
            S_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = stat.need_load ? S_LOAD : S_OUT;
            end
            S_LOAD:
            begin
                cmd.load_wb = 1'b1;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

### hw/rtl/rvs_dpath.sv
// Datapath of the RV32I step core: byte memory in four lanes, register file,
// pc, decode, ALU and result register. Depends on rvs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rvs_dpath (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire rvs_pkg::cmd_t    cmd,
    input  wire rvs_pkg::in_item_t in_data,
    output rvs_pkg::stat_t        stat,
    output rvs_pkg::out_item_t    out_data
);
    import rvs_pkg::*;

    function automatic logic [31:0] rf_init(input logic [4:0] a);
        logic [31:0] v;
        begin
            v = '0;
            if (a == 5'd2)
                v = SP_INIT;
            else if (a == 5'd3)
                v = GP_INIT;
            return v;
        end
    endfunction

    // ---------------- control state
    logic [ROW_W-1:0] clr_row_reg;
    logic [31:0]      pc_reg;
    logic             halted_reg;
    logic [31:0]      ins_reg;
    logic [31:0]      r1_reg, r2_reg;
    logic [31:0]      ea_reg;
    logic [2:0]       res_ev_reg;
    logic [31:0]      res_pv_reg;
    logic             res_fault_reg;
    out_item_t        out_reg;

    // ---------------- byte memory, four lanes of ROWS bytes
    logic [7:0]       mem_q_reg [4];
    logic [3:0]       mem_we;
    logic [ROW_W-1:0] mem_wrow;
    logic [7:0]       mem_wdata [4];
    logic             mem_re;
    logic [ROW_W-1:0] mem_rrow;

    genvar l;
    generate
        for (l = 0; l < 4; l++)
        begin : g_lane
            logic [7:0] lane_mem [ROWS];
            always_ff @(posedge clk)
            begin
                if (mem_we[l])
                    lane_mem[mem_wrow] <= mem_wdata[l];
                if (mem_re)
                    mem_q_reg[l] <= lane_mem[mem_rrow];
            end
        end
    endgenerate

    logic [31:0] mem_word;
    assign mem_word = {mem_q_reg[3], mem_q_reg[2], mem_q_reg[1], mem_q_reg[0]};

    // ---------------- register file
    logic [31:0] rf_mem [32];
    logic [31:0] rf_vld_reg;
    logic        rf_we;
    logic [4:0]  rf_wa;
    logic [31:0] rf_wd;
    logic [4:0]  rf_ra1, rf_ra2;

    always_ff @(posedge clk)
    begin
        if (rf_we)
            rf_mem[rf_wa] <= rf_wd;
        if (cmd.fetch)
        begin
            r1_reg <= (rf_ra1 == 5'd0) ? 32'd0 :
                      (rf_vld_reg[rf_ra1] ? rf_mem[rf_ra1] : rf_init(rf_ra1));
            r2_reg <= (rf_ra2 == 5'd0) ? 32'd0 :
                      (rf_vld_reg[rf_ra2] ? rf_mem[rf_ra2] : rf_init(rf_ra2));
        end
    end

    // ecall reads a7 and a0 through the two read ports
    assign rf_ra1 = (mem_word[6:0] == OPC_SYSTEM) ? REG_A7 : mem_word[19:15];
    assign rf_ra2 = (mem_word[6:0] == OPC_SYSTEM) ? REG_A0 : mem_word[24:20];

    // ---------------- decode
    logic [6:0]  opc, f7;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [31:0] imm_i, imm_s, imm_b, imm_j, imm_u;

    assign opc   = ins_reg[6:0];
    assign rd    = ins_reg[11:7];
    assign f3    = ins_reg[14:12];
    assign f7    = ins_reg[31:25];
    assign imm_i = {{20{ins_reg[31]}}, ins_reg[31:20]};
    assign imm_s = {{20{ins_reg[31]}}, ins_reg[31:25], ins_reg[11:7]};
    assign imm_b = {{20{ins_reg[31]}}, ins_reg[7], ins_reg[30:25], ins_reg[11:8], 1'b0};
    assign imm_j = {{12{ins_reg[31]}}, ins_reg[19:12], ins_reg[20], ins_reg[30:21], 1'b0};
    assign imm_u = {ins_reg[31:12], 12'd0};

    // ---------------- ALU
    logic [31:0] alu_b, alu_y;
    logic        alu_ok;
    logic        is_reg;

    assign is_reg = (opc == OPC_REG);
    assign alu_b  = is_reg ? r2_reg :
                    ((f3 == 3'd1 || f3 == 3'd5) ? {27'd0, ins_reg[24:20]} : imm_i);

    always_comb
    begin
        alu_y  = '0;
        alu_ok = 1'b1;
        unique case (f3)
            3'd0:
            begin
                if (!is_reg || f7 == F7_BASE)
                    alu_y = r1_reg + alu_b;
                else if (f7 == F7_ALT)
                    alu_y = r1_reg - alu_b;
                else
                    alu_ok = 1'b0;
            end
            3'd1: alu_y = r1_reg << alu_b[4:0];
            3'd2: alu_y = {31'd0, $signed(r1_reg) < $signed(alu_b)};
            3'd3: alu_y = {31'd0, r1_reg < alu_b};
            3'd4: alu_y = r1_reg ^ alu_b;
            3'd5:
            begin
                if (f7 == F7_BASE)
                    alu_y = r1_reg >> alu_b[4:0];
                else if (f7 == F7_ALT)
                    alu_y = 32'($signed(r1_reg) >>> alu_b[4:0]);
                else
                    alu_ok = 1'b0;
            end
            3'd6: alu_y = r1_reg | alu_b;
            3'd7: alu_y = r1_reg & alu_b;
            default: alu_ok = 1'b0;
        endcase
    end

    // ---------------- execute
    logic [31:0] ea;
    logic        ea_byte_ok, ea_word_ok;
    logic        take;
    logic        x_we;
    logic [31:0] x_wd;
    logic [31:0] x_npc;
    logic        x_fault;
    logic [2:0]  x_ev;
    logic [31:0] x_pv;
    logic        x_halt;
    logic [3:0]  x_st_we;
    logic        x_load;

    assign ea         = r1_reg + ((opc == OPC_STORE) ? imm_s : imm_i);
    assign ea_byte_ok = (ea < MEM_TOP);
    assign ea_word_ok = (ea[1:0] == 2'd0) && (ea <= WORD_LAST);

    always_comb
    begin
        unique case (f3)
            3'd0:    take = (r1_reg == r2_reg);
            3'd1:    take = (r1_reg != r2_reg);
            3'd4:    take = ($signed(r1_reg) < $signed(r2_reg));
            3'd5:    take = ($signed(r1_reg) >= $signed(r2_reg));
            3'd6:    take = (r1_reg < r2_reg);
            3'd7:    take = (r1_reg >= r2_reg);
            default: take = 1'b0;
        endcase
    end

    always_comb
    begin
        x_we    = 1'b0;
        x_wd    = '0;
        x_npc   = pc_reg + 32'd4;
        x_fault = 1'b0;
        x_ev    = EV_EXEC;
        x_pv    = '0;
        x_halt  = 1'b0;
        x_st_we = '0;
        x_load  = 1'b0;
        unique case (opc)
            OPC_REG, OPC_IMM:
            begin
                x_we = alu_ok;
                x_wd = alu_y;
            end
            OPC_LOAD:
            begin
                if (f3 == 3'd0 || f3 == 3'd4)
                begin
                    x_load  = ea_byte_ok;
                    x_fault = !ea_byte_ok;
                end
                else if (f3 == 3'd2)
                begin
                    x_load  = ea_word_ok;
                    x_fault = !ea_word_ok;
                end
                // faulting load writes all ones to rd
                x_we = x_fault;
                x_wd = '1;
            end
            OPC_STORE:
            begin
                if (f3 == 3'd0)
                begin
                    x_fault = !ea_byte_ok;
                    if (ea_byte_ok)
                        x_st_we[ea[1:0]] = 1'b1;
                end
                else if (f3 == 3'd2)
                begin
                    x_fault = !ea_word_ok;
                    if (ea_word_ok)
                        x_st_we = '1;
                end
            end
            OPC_BRANCH:
            begin
                if (take)
                    x_npc = pc_reg + imm_b;
            end
            OPC_LUI:
            begin
                x_we = 1'b1;
                x_wd = imm_u;
            end
            OPC_AUIPC:
            begin
                x_we = 1'b1;
                x_wd = pc_reg + imm_u;
            end
            OPC_JAL:
            begin
                x_we  = 1'b1;
                x_wd  = pc_reg + 32'd4;
                x_npc = pc_reg + imm_j;
            end
            OPC_JALR:
            begin
                x_we  = 1'b1;
                x_wd  = pc_reg + 32'd4;
                x_npc = {ea[31:1], 1'b0};
            end
            OPC_SYSTEM:
            begin
                if (r1_reg == CALL_PRINT)
                begin
                    x_ev = EV_PRINT;
                    x_pv = r2_reg;
                end
                else if (r1_reg == CALL_EXIT)
                begin
                    x_ev   = EV_EXIT;
                    x_halt = 1'b1;
                end
            end
            default:
            begin
                x_we = 1'b0;
            end
        endcase
    end

    // ---------------- load write-back
    logic [7:0]  ld_byte;
    logic [31:0] ld_val;

    assign ld_byte = mem_q_reg[ea_reg[1:0]];

    always_comb
    begin
        if (f3 == 3'd2)
            ld_val = mem_word;
        else if (f3 == 3'd0)
            ld_val = {{24{ld_byte[7]}}, ld_byte};
        else
            ld_val = {24'd0, ld_byte};
    end

    always_comb
    begin
        rf_wa = rd;
        if (cmd.load_wb)
        begin
            rf_we = (rd != 5'd0);
            rf_wd = ld_val;
        end
        else
        begin
            rf_we = cmd.exec && x_we && (rd != 5'd0);
            rf_wd = x_wd;
        end
    end

    // ---------------- memory port selection
    logic [31:0] la32;
    logic        la_ok;
    logic        pc_ok;

    assign la32  = 32'(in_data.load_address);
    assign la_ok = (la32 < MEM_TOP);
    assign pc_ok = (pc_reg[1:0] == 2'd0) && (pc_reg <= WORD_LAST);

    always_comb
    begin
        mem_we    = '0;
        mem_wrow  = ea[ROW_W+1:2];
        for (int k = 0; k < 4; k++)
            mem_wdata[k] = r2_reg[8*k +: 8];
        if (cmd.clear)
        begin
            mem_we   = '1;
            mem_wrow = clr_row_reg;
            for (int k = 0; k < 4; k++)
                mem_wdata[k] = 8'd0;
        end
        else if (cmd.accept && !in_data.op)
        begin
            mem_we[la32[1:0]] = la_ok;
            mem_wrow          = la32[ROW_W+1:2];
            for (int k = 0; k < 4; k++)
                mem_wdata[k] = in_data.load_byte;
        end
        else if (cmd.exec)
        begin
            // a byte store drives the low byte on its own lane
            mem_we = x_st_we;
            if (f3 == 3'd0)
                for (int k = 0; k < 4; k++)
                    mem_wdata[k] = r2_reg[7:0];
        end
    end

    assign mem_re   = cmd.accept || cmd.exec;
    assign mem_rrow = cmd.accept ? pc_reg[ROW_W+1:2] : ea[ROW_W+1:2];

    // ---------------- state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_row_reg <= '0;
            pc_reg      <= '0;
            halted_reg  <= 1'b0;
            rf_vld_reg  <= '0;
        end
        else
        begin
            if (cmd.clear)
                clr_row_reg <= clr_row_reg + 1'b1;
            if (rf_we)
                rf_vld_reg[rf_wa] <= 1'b1;
            if (cmd.accept && in_data.op && !halted_reg && !pc_ok)
                halted_reg <= 1'b1;
            if (cmd.exec)
            begin
                pc_reg <= x_npc;
                if (x_halt)
                    halted_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            res_pv_reg    <= '0;
            res_fault_reg <= 1'b0;
            if (!in_data.op)
                res_ev_reg <= EV_WRITE;
            else if (halted_reg)
                res_ev_reg <= pc_ok ? EV_EXIT : EV_PCFAULT;
            else
                res_ev_reg <= EV_PCFAULT;
        end
        if (cmd.fetch)
            ins_reg <= mem_word;
        if (cmd.exec)
        begin
            res_ev_reg    <= x_ev;
            res_pv_reg    <= x_pv;
            res_fault_reg <= x_fault;
            ea_reg        <= ea;
        end
        if (cmd.out_load)
        begin
            out_reg.event_res    <= res_ev_reg;
            out_reg.print_value  <= res_pv_reg;
            out_reg.next_pc      <= pc_reg;
            out_reg.access_fault <= res_fault_reg;
        end
    end

    assign stat.clear_done = (clr_row_reg == ROW_W'(ROWS - 1));
    assign stat.need_fetch = in_data.op && !halted_reg && pc_ok;
    assign stat.need_load  = x_load;
    assign out_data        = out_reg;

endmodule

`default_nettype wire

### hw/rtl/rv32i_subset_core_step.sv
// Top level of the RV32I step core: sequencer plus datapath.
// Depends on rvs_pkg, rvs_ctrl and rvs_dpath.
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+---------------------
//   input   | in_valid  | in_stall  | in_data  (in_item_t)
//   output  | out_valid | out_stall | out_data (out_item_t)
//
// A byte-write beat passes through accept and result load, as does an execute
// beat on a halted core or an unfetchable pc. An executed instruction passes
// through instruction read, register read, execute and result load; a load
// adds a write-back step, since it reads memory again before write-back.
// After reset the byte memory is zeroed one row of 4 bytes a cycle, all
// MEM_BYTES/4 = 4096 rows, with in_stall high throughout.
// One beat is in flight at a time; a finished result sits in the output
// register while the next input beat is taken.
`timescale 1ns / 1ps
`default_nettype none

module rv32i_subset_core_step (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire rvs_pkg::in_item_t in_data,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output rvs_pkg::out_item_t     out_data
);
    import rvs_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    rvs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    rvs_dpath u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_data  (in_data),
        .stat     (stat),
        .out_data (out_data)
    );

endmodule

`default_nettype wire

### bench/tb.sv
// Self-checking bench for rv32i_subset_core_step: byte loads build small programs,
// execute beats run them, and a local instruction-set model predicts every result.
// Depends on rvs_pkg and the rv32i_subset_core_step RTL.
`timescale 1ns / 1ps
`default_nettype none

module tb;
    import rvs_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_data;

    rv32i_subset_core_step dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // shadow of the core's architectural state
    logic [7:0]  shadow_mem [MEM_BYTES];
    logic [31:0] shadow_regs [32];
    logic [31:0] shadow_pc;
    logic        shadow_halted;

    out_item_t expected_results [$];
    int        mismatch_count;
    int        result_count;
    int        beats_sent;
    int        exec_sent;
    int        print_seen;
    int        halt_seen;
    int        idle_cycles;
    bit        timed_out;

    initial clk = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [31:0] reg_read(input logic [4:0] idx);
        return (idx == 5'd0) ? 32'd0 : shadow_regs[idx];
    endfunction

    function automatic bit word_fits(input logic [31:0] a);
        return (a[1:0] == 2'b00) && ({32'd0, a} + 64'd4 <= 64'(MEM_BYTES));
    endfunction

    function automatic logic [31:0] mem_word(input logic [31:0] a);
        return {shadow_mem[a + 3], shadow_mem[a + 2], shadow_mem[a + 1], shadow_mem[a]};
    endfunction

    // one instruction-set step on the shadow state
    function automatic out_item_t core_step(input in_item_t it);
        out_item_t   r;
        logic [31:0] ins, r1, r2, imm_i, imm_s, imm_b, imm_j, npc, v, ea, opb;
        logic [6:0]  opc, f7;
        logic [4:0]  rd;
        logic [2:0]  f3;
        bit          wr, take;
        r = '0;
        r.event_res = EV_EXEC;
        if (!it.op)
        begin
            if (32'(it.load_address) < MEM_TOP)
                shadow_mem[it.load_address] = it.load_byte;
            r.event_res = EV_WRITE;
        end
        else if (shadow_halted)
            r.event_res = word_fits(shadow_pc) ? EV_EXIT : EV_PCFAULT;
        else if (!word_fits(shadow_pc))
        begin
            shadow_halted = 1'b1;
            r.event_res = EV_PCFAULT;
        end
        else
        begin
            ins   = mem_word(shadow_pc);
            opc   = ins[6:0];
            rd    = ins[11:7];
            f3    = ins[14:12];
            f7    = ins[31:25];
            r1    = reg_read(ins[19:15]);
            r2    = reg_read(ins[24:20]);
            imm_i = {{20{ins[31]}}, ins[31:20]};
            imm_s = {{20{ins[31]}}, ins[31:25], ins[11:7]};
            imm_b = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
            imm_j = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
            npc   = shadow_pc + 32'd4;
            case (opc)
                OPC_REG, OPC_IMM:
                begin
                    if (opc == OPC_REG)
                        opb = r2;
                    else
                        opb = (f3 == 3'd1 || f3 == 3'd5) ? {27'd0, ins[24:20]} : imm_i;
                    wr = 1'b1;
                    v = '0;
                    case (f3)
                        3'd0:
                            if (opc == OPC_IMM || f7 == F7_BASE) v = r1 + opb;
                            else if (f7 == F7_ALT) v = r1 - opb;
                            else wr = 1'b0;
                        3'd1: v = r1 << opb[4:0];
                        3'd2: v = ($signed(r1) < $signed(opb)) ? 32'd1 : 32'd0;
                        3'd3: v = (r1 < opb) ? 32'd1 : 32'd0;
                        3'd4: v = r1 ^ opb;
                        3'd5:
                            if (f7 == F7_BASE) v = r1 >> opb[4:0];
                            else if (f7 == F7_ALT) v = $unsigned($signed(r1) >>> opb[4:0]);
                            else wr = 1'b0;
                        3'd6: v = r1 | opb;
                        default: v = r1 & opb;
                    endcase
                    if (wr && rd != 5'd0) shadow_regs[rd] = v;
                end
                OPC_LOAD:
                begin
                    ea = r1 + imm_i;
                    v = 32'hFFFF_FFFF;
                    if (f3 == 3'd0 || f3 == 3'd4 || f3 == 3'd2)
                    begin
                        if (f3 == 3'd2 ? word_fits(ea) : (ea < MEM_TOP))
                        begin
                            if (f3 == 3'd2) v = mem_word(ea);
                            else if (f3 == 3'd0) v = {{24{shadow_mem[ea][7]}}, shadow_mem[ea]};
                            else v = {24'd0, shadow_mem[ea]};
                        end
                        else
                            r.access_fault = 1'b1;
                        if (rd != 5'd0) shadow_regs[rd] = v;
                    end
                end
                OPC_STORE:
                begin
                    ea = r1 + imm_s;
                    if (f3 == 3'd0)
                    begin
                        if (ea < MEM_TOP) shadow_mem[ea] = r2[7:0];
                        else r.access_fault = 1'b1;
                    end
                    else if (f3 == 3'd2)
                    begin
                        if (word_fits(ea))
                            for (int k = 0; k < 4; k++)
                                shadow_mem[ea + k] = r2[8*k +: 8];
                        else
                            r.access_fault = 1'b1;
                    end
                end
                OPC_BRANCH:
                begin
                    case (f3)
                        3'd0: take = (r1 == r2);
                        3'd1: take = (r1 != r2);
                        3'd4: take = ($signed(r1) < $signed(r2));
                        3'd5: take = !($signed(r1) < $signed(r2));
                        3'd6: take = (r1 < r2);
                        3'd7: take = (r1 >= r2);
                        default: take = 1'b0;
                    endcase
                    if (take) npc = shadow_pc + imm_b;
                end
                OPC_LUI:
                    if (rd != 5'd0) shadow_regs[rd] = {ins[31:12], 12'd0};
                OPC_AUIPC:
                    if (rd != 5'd0) shadow_regs[rd] = shadow_pc + {ins[31:12], 12'd0};
                OPC_JAL:
                begin
                    if (rd != 5'd0) shadow_regs[rd] = shadow_pc + 32'd4;
                    npc = shadow_pc + imm_j;
                end
                OPC_JALR:
                begin
                    npc = (r1 + imm_i) & ~32'd1;
                    if (rd != 5'd0) shadow_regs[rd] = shadow_pc + 32'd4;
                end
                OPC_SYSTEM:
                begin
                    v = reg_read(REG_A7);
                    if (v == CALL_PRINT)
                    begin
                        r.event_res = EV_PRINT;
                        r.print_value = reg_read(REG_A0);
                    end
                    else if (v == CALL_EXIT)
                    begin
                        r.event_res = EV_EXIT;
                        shadow_halted = 1'b1;
                    end
                end
                default: ;
            endcase
            shadow_pc = npc;
        end
        r.next_pc = shadow_pc;
        return r;
    endfunction

    // random gap: mostly none or short, now and then long
    function automatic int pick_gap();
        int p;
        p = $urandom_range(99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    bit burst_mode;

    task automatic send_beat(input logic op, input logic [13:0] addr, input logic [7:0] data);
        in_item_t it;
        int gap;
        it.op = op;
        it.load_address = addr;
        it.load_byte = data;
        gap = burst_mode ? 0 : pick_gap();
        // valid drops between beats; the core is busy then anyway
        repeat (gap + 1) @(posedge clk);
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        expected_results.push_back(core_step(it));
        beats_sent++;
        if (op) exec_sent++;
        in_valid <= 1'b0;
    endtask

    task automatic load_word(input logic [31:0] addr, input logic [31:0] w);
        for (int k = 0; k < 4; k++)
            send_beat(1'b0, 14'(addr + k), w[8*k +: 8]);
    endtask

    task automatic run_steps(input int n);
        repeat (n) send_beat(1'b1, 14'($urandom), 8'($urandom));
    endtask

    // waits until every result has come back, so the core sits idle
    task automatic drain();
        while (expected_results.size() != 0 && !timed_out) @(posedge clk);
    endtask

    function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [4:0] rs2,
                                          input logic [4:0] rs1, input logic [2:0] f3,
                                          input logic [4:0] rd, input logic [6:0] opc);
        return {f7, rs2, rs1, f3, rd, opc};
    endfunction

    function automatic logic [31:0] enc_i(input logic [11:0] imm, input logic [4:0] rs1,
                                          input logic [2:0] f3, input logic [4:0] rd,
                                          input logic [6:0] opc);
        return {imm, rs1, f3, rd, opc};
    endfunction

    function automatic logic [31:0] enc_s(input logic [11:0] imm, input logic [4:0] rs2,
                                          input logic [4:0] rs1, input logic [2:0] f3);
        return {imm[11:5], rs2, rs1, f3, imm[4:0], OPC_STORE};
    endfunction

    function automatic logic [31:0] enc_b(input logic [12:0] imm, input logic [4:0] rs2,
                                          input logic [4:0] rs1, input logic [2:0] f3);
        return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OPC_BRANCH};
    endfunction

    // a plausible instruction: mostly legal encodings, some junk
    function automatic logic [31:0] rand_insn(input logic [31:0] at);
        logic [4:0]  rd, rs1, rs2;
        logic [2:0]  f3;
        logic [11:0] imm;
        int          pick;
        rd  = 5'($urandom_range(0, 15));
        rs1 = 5'($urandom_range(0, 15));
        rs2 = 5'($urandom_range(0, 15));
        f3  = 3'($urandom);
        imm = 12'($urandom);
        pick = $urandom_range(99);
        if ($urandom_range(3) == 0) rs1 = 5'd3;   // gp points at data
        if (pick < 20)
            return enc_r(($urandom_range(9) == 0) ? 7'($urandom) :
                         ($urandom_range(1) ? F7_ALT : F7_BASE), rs2, rs1, f3, rd, OPC_REG);
        if (pick < 40)
        begin
            if (f3 == 3'd5 || f3 == 3'd1)
                imm[11:5] = ($urandom_range(9) == 0) ? 7'($urandom) :
                            ($urandom_range(1) ? F7_ALT : F7_BASE);
            return enc_i(imm, rs1, f3, rd, OPC_IMM);
        end
        if (pick < 52)
        begin
            if ($urandom_range(3) != 0) f3 = ($urandom_range(2) == 0) ? 3'd0 :
                                             ($urandom_range(1) ? 3'd2 : 3'd4);
            if ($urandom_range(3) != 0) imm = 12'($urandom_range(0, 255));
            return enc_i(imm, rs1, f3, rd, OPC_LOAD);
        end
        if (pick < 62)
        begin
            if ($urandom_range(3) != 0) f3 = $urandom_range(1) ? 3'd2 : 3'd0;
            // keep stores mostly in the data area, away from the code
            if ($urandom_range(3) != 0) begin rs1 = 5'd3; imm = 12'($urandom_range(0, 255)); end
            return enc_s(imm, rs2, rs1, f3);
        end
        if (pick < 72)
            return enc_b(13'($urandom_range(0, 6) * 4 - 8), rs2, rs1, f3);
        if (pick < 77)
            return {20'($urandom), rd, OPC_LUI};
        if (pick < 81)
            return {20'($urandom), rd, OPC_AUIPC};
        if (pick < 85)
            return {1'b0, 10'($urandom_range(1, 3) * 2), 1'b0, 8'd0, rd, OPC_JAL};
        if (pick < 88)
            return enc_i(12'(at + 8), 5'd0, f3, rd, OPC_JALR);
        if (pick < 94)
            return enc_i(12'(CALL_PRINT), 5'd0, 3'd0, REG_A7, OPC_IMM);   // li a7, 1
        if (pick < 97)
            return enc_i(12'h000, 5'd0, 3'd0, 5'd0, OPC_SYSTEM);
        return $urandom;
    endfunction

    task automatic test_reset_state();
        // fresh core: pc 0 holds zeros, an unknown opcode
        run_steps(1);
        send_beat(1'b0, 14'h3FFF, 8'hFF);
        send_beat(1'b0, 14'h0000, 8'h00);
        drain();
    endtask

    task automatic test_directed();
        logic [31:0] prog [$];
        logic [31:0] base;
        base = shadow_pc;
        prog = '{
            enc_i(12'h7FF, 5'd0, 3'd0, 5'd5, OPC_IMM),           // addi x5, x0, 2047
            enc_i(12'h800, 5'd0, 3'd0, 5'd6, OPC_IMM),           // addi x6, x0, -2048
            enc_r(F7_ALT, 5'd5, 5'd6, 3'd5, 5'd7, OPC_REG),       // sra
            enc_r(F7_ALT, 5'd5, 5'd6, 3'd0, 5'd0, OPC_REG),       // sub to x0
            enc_s(12'h0, 5'd6, 5'd2, 3'd2),                       // sw top word
            enc_i(12'h000, 5'd2, 3'd0, 5'd8, OPC_LOAD),           // lb top byte
            enc_i(12'h001, 5'd2, 3'd2, 5'd9, OPC_LOAD),           // lw misaligned
            enc_i(12'h004, 5'd2, 3'd4, 5'd9, OPC_LOAD),           // lbu out of range
            enc_s(12'h004, 5'd6, 5'd2, 3'd0),                     // sb out of range
            enc_i(12'd1, 5'd0, 3'd0, REG_A7, OPC_IMM),
            enc_i(12'h000, 5'd0, 3'd0, 5'd0, OPC_SYSTEM),         // print a0
            {20'hFFFFF, 5'd10, OPC_LUI},
            enc_i(12'h000, 5'd0, 3'd0, 5'd0, OPC_SYSTEM),
            enc_b(13'd8, 5'd6, 5'd5, 3'd4),                       // blt not taken
            enc_b(13'd8, 5'd6, 5'd5, 3'd6),                       // bltu taken
            32'h0,
            enc_i(12'd10, 5'd0, 3'd0, REG_A7, OPC_IMM),
            enc_i(12'h000, 5'd0, 3'd0, 5'd0, OPC_SYSTEM)          // exit
        };
        foreach (prog[k]) load_word(base + 4 * k, prog[k]);
        run_steps(prog.size());
        run_steps(2);                                             // halted core
        drain();
    endtask

    task automatic reset_core_view();
        // core stays halted forever in hardware: only halt reporting is checked
        run_steps(1);
        drain();
    endtask

    task automatic test_random_programs();
        logic [31:0] base;
        int          n;
        // the core cannot be restarted after halt, so random code avoids exit calls
        // until the end; each program lives at the current pc
        while (beats_sent < 1650 && !timed_out && !shadow_halted)
        begin
            base = shadow_pc;
            if (!word_fits(base) || base + 64 > MEM_TOP) break;
            n = $urandom_range(4, 12);
            for (int k = 0; k < n; k++) load_word(base + 4 * k, rand_insn(base + 4 * k));
            burst_mode = ($urandom_range(3) == 0);
            run_steps(n + $urandom_range(0, 2));
            burst_mode = 1'b0;
        end
        // an early halt leaves the item budget short: fill it with mixed beats
        while (beats_sent < 1650 && !timed_out)
            send_beat(1'($urandom), 14'($urandom), 8'($urandom));
        drain();
    endtask

    task automatic test_pc_fault();
        // jump out of memory, then a halted execute and a write while halted
        load_word(shadow_pc, {1'b1, 10'd0, 1'b0, 8'hFF, 5'd1, OPC_JAL});
        run_steps(3);
        send_beat(1'b0, 14'($urandom), 8'($urandom));
        run_steps(1);
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        mismatch_count = 0;
        result_count = 0;
        beats_sent = 0;
        exec_sent = 0;
        print_seen = 0;
        halt_seen = 0;
        timed_out = 1'b0;
        burst_mode = 1'b0;
        foreach (shadow_mem[k]) shadow_mem[k] = 8'h00;
        foreach (shadow_regs[k]) shadow_regs[k] = 32'd0;
        shadow_regs[2] = SP_INIT;
        shadow_regs[3] = GP_INIT;
        shadow_pc = 32'd0;
        shadow_halted = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_random_programs();
        if (!shadow_halted) test_directed();
        test_pc_fault();
        reset_core_view();

        repeat (20) @(posedge clk);
        $display("%0d beats sent (%0d execute), %0d results checked", beats_sent, exec_sent,
                 result_count);
        $display("%0d print calls and %0d halt reports seen", print_seen, halt_seen);
        if (mismatch_count == 0 && expected_results.size() == 0 && !timed_out)
            $display("** rv32i_subset_core_step: PASSED **");
        else
            $display("** rv32i_subset_core_step: FAILED **");
        $finish;
    end

    // receiver stall pattern
    int stall_left;
    bit calm;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
            calm       <= 1'b0;
        end
        else if (stall_left > 0)
            stall_left <= stall_left - 1;
        else
        begin
            calm <= ($urandom_range(15) == 0) ? !calm : calm;
            if (!calm && $urandom_range(2) == 0)
            begin
                out_stall  <= 1'b1;
                stall_left <= ($urandom_range(9) == 0) ? $urandom_range(8, 25)
                                                        : $urandom_range(0, 2);
            end
            else
                out_stall <= 1'b0;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            result_count++;
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result beat %p", out_data);
            end
            else
            begin
                want = expected_results.pop_front();
                if (out_data.event_res == EV_PRINT) print_seen++;
                if (out_data.event_res == EV_EXIT || out_data.event_res == EV_PCFAULT)
                    halt_seen++;
                if (out_data.event_res !== want.event_res ||
                    out_data.print_value !== want.print_value ||
                    out_data.next_pc !== want.next_pc ||
                    out_data.access_fault !== want.access_fault)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"mismatch: expected ev=%0d pv=%h pc=%h af=%b",
                                  " got ev=%0d pv=%h pc=%h af=%b"},
                                 want.event_res, want.print_value, want.next_pc,
                                 want.access_fault, out_data.event_res, out_data.print_value,
                                 out_data.next_pc, out_data.access_fault);
                end
            end
        end
    end

    // watchdog on cycles without any accepted beat; its limit covers the memory clear after reset
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (in_valid || expected_results.size() != 0)
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                timed_out = 1'b1;
                $display("** rv32i_subset_core_step: FAILED **");
                $finish;
            end
        end
        else
            idle_cycles <= 0;
    end

endmodule

`default_nettype wire
